[rtl/mpct_pkg.sv]
// Package with the constants and transfer types of the mouse packet cursor tracker.
`timescale 1ns / 1ps

package mpct_pkg;

    // Screen geometry and cursor start position
    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int START_COL = 40;
    localparam int START_ROW = 12;

    localparam int POS_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int BTN_W   = 3;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 10;

    localparam logic [IDX_W-1:0] LAST_BYTE_IDX = IDX_W'(2);

    localparam logic [POS_W-1:0] START_COL_POS = POS_W'(START_COL);
    localparam logic [POS_W-1:0] START_ROW_POS = POS_W'(START_ROW);
    localparam logic [POS_W-1:0] COL_MAX       = POS_W'(COLS - 1);
    localparam logic [POS_W-1:0] ROW_MAX       = POS_W'(ROWS - 1);

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_FLAG = 1'b1;

    // Result action codes
    localparam logic ACT_INVERT   = 1'b0;
    localparam logic ACT_ANNOUNCE = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] data_byte;
        logic              flag_value;
    } in_item_t;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] cell_col;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cursor_col;
        logic [POS_W-1:0] cursor_row;
        logic             disabled;
        logic             last;
    } out_item_t;

endpackage

[rtl/mouse_packet_cursor_tracker_top.sv]
// Top level of the mouse packet cursor tracker: packet framing, cursor update, result queue.
`timescale 1ns / 1ps

// Mouse packet cursor tracker. Each s_ transfer carries either a raw mouse byte
// (operation 0) or a write of the render-started flag (operation 1). Bytes are
// framed into three-byte packets; on the third byte the cursor moves by the
// signed X delta (byte 1) and against the signed Y delta (byte 2), clamped to
// the COLS x ROWS screen, and the three button bits of byte 0 drive the
// press latch that toggles the disabled flag. A complete packet yields up to
// two m_ transfers (cell inverts of old and new cursor, or an erase followed
// by a state notice); the final one of each packet has last set. An accepted
// item is held in the input register, then is decoded in a single pass into
// a two-entry result queue once that queue can take it. Items that give no
// result, or one result, flow at one per cycle while m_ready stays high; a
// packet that gives two results holds the next item back while the single
// m_ port drains the queue. m_valid is registered: the input register and
// the result queue lie between an s_ transfer and its first m_ transfer.
module mouse_packet_cursor_tracker_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mpct_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mpct_pkg::out_item_t   m_data
);

    // Input register
    logic                 in_valid_reg, in_valid_next;
    mpct_pkg::in_item_t   in_item_reg;
    logic                 in_fire;

    // Tracker state
    logic [mpct_pkg::IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [mpct_pkg::BYTE_W-1:0] byte0_reg, byte0_next;
    logic [mpct_pkg::BYTE_W-1:0] byte1_reg, byte1_next;
    logic [mpct_pkg::POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [mpct_pkg::POS_W-1:0]  row_pos_reg, row_pos_next;
    logic [mpct_pkg::BTN_W-1:0]  prev_buttons_reg, prev_buttons_next;
    logic                        disabled_reg, disabled_next;
    logic                        press_latch_reg, press_latch_next;
    logic                        erase_pending_reg, erase_pending_next;
    logic                        render_started_reg, render_started_next;

    // Result queue: head drives m_data, tail holds the second result
    mpct_pkg::out_item_t head_reg, head_next;
    mpct_pkg::out_item_t tail_reg, tail_next;
    logic [1:0]          count_reg, count_next;

    // Decode results
    mpct_pkg::out_item_t res0, res1;
    logic [1:0]          res_count;

    logic pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

    // Move the held item into the queue once the queue will be empty after this cycle
    assign in_fire = in_valid_reg &&
                     ((count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready));
    assign s_ready = !in_valid_reg || in_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Single-pass decode of the held item
    always_comb begin
        logic signed [mpct_pkg::SUM_W-1:0] col_sum;
        logic signed [mpct_pkg::SUM_W-1:0] row_sum;
        logic [mpct_pkg::BYTE_W-1:0]       dy;
        logic                              latch;
        logic                              dis;
        logic                              erase;
        logic [mpct_pkg::POS_W-1:0]        new_col;
        logic [mpct_pkg::POS_W-1:0]        new_row;

        byte_index_next     = byte_index_reg;
        byte0_next          = byte0_reg;
        byte1_next          = byte1_reg;
        col_pos_next        = col_pos_reg;
        row_pos_next        = row_pos_reg;
        prev_buttons_next   = prev_buttons_reg;
        disabled_next       = disabled_reg;
        press_latch_next    = press_latch_reg;
        erase_pending_next  = erase_pending_reg;
        render_started_next = render_started_reg;
        res0                = '0;
        res1                = '0;
        res_count           = 2'd0;

        dy = in_item_reg.data_byte;

        // Clamp with wide signed arithmetic
        col_sum = $signed({3'b000, col_pos_reg}) +
                  $signed({{(mpct_pkg::SUM_W-mpct_pkg::BYTE_W){byte1_reg[7]}}, byte1_reg});
        row_sum = $signed({3'b000, row_pos_reg}) -
                  $signed({{(mpct_pkg::SUM_W-mpct_pkg::BYTE_W){dy[7]}}, dy});

        if (col_sum < 0) begin
            new_col = '0;
        end else if (col_sum >= $signed(mpct_pkg::SUM_W'(mpct_pkg::COLS))) begin
            new_col = mpct_pkg::COL_MAX;
        end else begin
            new_col = col_sum[mpct_pkg::POS_W-1:0];
        end

        if (row_sum < 0) begin
            new_row = '0;
        end else if (row_sum >= $signed(mpct_pkg::SUM_W'(mpct_pkg::ROWS))) begin
            new_row = mpct_pkg::ROW_MAX;
        end else begin
            new_row = row_sum[mpct_pkg::POS_W-1:0];
        end

        // Scan buttons in order; each change flips the press latch
        latch = press_latch_reg;
        dis   = disabled_reg;
        erase = erase_pending_reg;
        for (int i = 0; i < mpct_pkg::BTN_W; i++) begin
            if (byte0_reg[i] != prev_buttons_reg[i]) begin
                if (!latch) begin
                    dis   = ~dis;
                    latch = 1'b1;
                    erase = 1'b1;
                end else begin
                    latch = 1'b0;
                end
            end
        end

        if (in_fire) begin
            if (in_item_reg.operation == mpct_pkg::OP_FLAG) begin
                render_started_next = in_item_reg.flag_value;
            end else if (byte_index_reg != mpct_pkg::LAST_BYTE_IDX) begin
                // Hold the byte until the packet is complete
                if (byte_index_reg == '0) begin
                    byte0_next = in_item_reg.data_byte;
                end else begin
                    byte1_next = in_item_reg.data_byte;
                end
                byte_index_next = byte_index_reg + 1'b1;
            end else begin
                byte_index_next   = '0;
                col_pos_next      = new_col;
                row_pos_next      = new_row;
                prev_buttons_next = byte0_reg[mpct_pkg::BTN_W-1:0];
                disabled_next     = dis;
                press_latch_next  = latch;
                erase_pending_next = erase;

                // Common fields of every result of this packet
                res0.cursor_col = new_col;
                res0.cursor_row = new_row;
                res0.disabled   = dis;
                res1.cursor_col = new_col;
                res1.cursor_row = new_row;
                res1.disabled   = dis;

                if (!dis) begin
                    render_started_next = 1'b1;
                    if (render_started_reg) begin
                        // Invert old cursor, then new cursor
                        res0.action   = mpct_pkg::ACT_INVERT;
                        res0.cell_col = col_pos_reg;
                        res0.cell_row = row_pos_reg;
                        res0.last     = 1'b0;
                        res1.action   = mpct_pkg::ACT_INVERT;
                        res1.cell_col = new_col;
                        res1.cell_row = new_row;
                        res1.last     = 1'b1;
                        res_count     = 2'd2;
                    end else begin
                        res0.action   = mpct_pkg::ACT_INVERT;
                        res0.cell_col = new_col;
                        res0.cell_row = new_row;
                        res0.last     = 1'b1;
                        res_count     = 2'd1;
                    end
                end else if (erase) begin
                    // Erase old cursor, then announce the state
                    erase_pending_next  = 1'b0;
                    render_started_next = 1'b0;
                    res0.action   = mpct_pkg::ACT_INVERT;
                    res0.cell_col = col_pos_reg;
                    res0.cell_row = row_pos_reg;
                    res0.last     = 1'b0;
                    res1.action   = mpct_pkg::ACT_ANNOUNCE;
                    res1.last     = 1'b1;
                    res_count     = 2'd2;
                end
            end
        end
    end

    // Result queue update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (in_fire) begin
            // Queue is drained this cycle; load fresh results
            head_next  = res0;
            tail_next  = res1;
            count_next = res_count;
        end else if (pop) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            byte_index_reg     <= '0;
            col_pos_reg        <= mpct_pkg::START_COL_POS;
            row_pos_reg        <= mpct_pkg::START_ROW_POS;
            prev_buttons_reg   <= '0;
            disabled_reg       <= 1'b0;
            press_latch_reg    <= 1'b0;
            erase_pending_reg  <= 1'b0;
            render_started_reg <= 1'b0;
            count_reg          <= 2'd0;
        end else begin
            in_valid_reg       <= in_valid_next;
            byte_index_reg     <= byte_index_next;
            col_pos_reg        <= col_pos_next;
            row_pos_reg        <= row_pos_next;
            prev_buttons_reg   <= prev_buttons_next;
            disabled_reg       <= disabled_next;
            press_latch_reg    <= press_latch_next;
            erase_pending_reg  <= erase_pending_next;
            render_started_reg <= render_started_next;
            count_reg          <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
    end

endmodule
